// ===== hdl/ldf_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// Used by ldf_parse, ldf_emit and length_prefixed_deframer_core.
`default_nettype none

package ldf_pkg;

    // Frame format
    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned LENGTH_BITS  = 16;

    // Largest length the header may carry, independent of the register
    localparam logic [32:0] WIDTH_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    // Register reset value
    localparam logic [15:0] MAX_LEN_RESET = 16'd3000;

    // Index of the last header byte and size of a header burst
    localparam logic [1:0] HDR_LAST    = 2'(HEADER_BYTES - 1);
    localparam logic [2:0] BURST_FULL  = 3'(HEADER_BYTES);
    localparam logic [2:0] BURST_ONE   = 3'd1;
    localparam logic [2:0] BURST_EMPTY = 3'd0;

    // Request kinds
    localparam logic MODE_DATA    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    // Results caused by one request, handed from parser to output stage
    typedef struct packed {
        logic [2:0]  count;         // number of results, 0 to 4
        logic [31:0] bytes;         // first result byte in the top lane
        logic        header;
        logic        error;
        logic        frame_end;     // applies to the last result of the burst
        logic [15:0] frame_length;
        logic        swapped;
    } burst_t;

endpackage

`default_nettype wire

// ===== hdl/ldf_parse.sv =====
// Input register and frame parser: header collection, length check, payload count.
// Depends on ldf_pkg; feeds a burst_t to ldf_emit.
`default_nettype none

module ldf_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic           mode,
    input  wire logic [7:0]     data_byte,
    input  wire logic [15:0]    max_len,
    input  wire logic           emit_ready,
    output ldf_pkg::burst_t     burst,
    output logic                burst_load
);
    import ldf_pkg::*;

    // Input register
    logic        in_full_reg;
    logic        mode_reg;
    logic [7:0]  byte_reg;

    // Frame state
    logic [23:0] header_hold_reg,     header_hold_next;
    logic [1:0]  header_count_reg,    header_count_next;
    logic        in_payload_reg,      in_payload_next;
    logic [15:0] payload_left_reg,    payload_left_next;
    logic [15:0] current_length_reg,  current_length_next;
    logic        current_swapped_reg, current_swapped_next;
    logic        halted_reg,          halted_next;

    logic        advance;
    logic [31:0] big_len;
    logic [31:0] little_len;
    logic [31:0] limit;
    logic        big_ok;
    logic        little_ok;

    assign advance    = in_full_reg && emit_ready;
    assign in_stall   = in_full_reg && !advance;
    assign burst_load = advance;

    // Capture a request whenever the register is free or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg <= mode;
            byte_reg <= data_byte;
        end
    end

    // Both readings of the header and the clipped limit
    assign big_len    = {header_hold_reg, byte_reg};
    assign little_len = {byte_reg, header_hold_reg[7:0], header_hold_reg[15:8],
                         header_hold_reg[23:16]};
    assign limit      = ({16'd0, max_len} > WIDTH_MAX[31:0]) ? WIDTH_MAX[31:0]
                                                             : {16'd0, max_len};
    assign big_ok     = big_len <= limit;
    assign little_ok  = little_len <= limit;

    // Next frame state and the results of this request
    always_comb
    begin
        header_hold_next     = header_hold_reg;
        header_count_next    = header_count_reg;
        in_payload_next      = in_payload_reg;
        payload_left_next    = payload_left_reg;
        current_length_next  = current_length_reg;
        current_swapped_next = current_swapped_reg;
        halted_next          = halted_reg;
        burst                = '0;

        if (advance)
        begin
            if (mode_reg == MODE_RESTART)
            begin
                // Drop any partial frame and leave the error state
                header_hold_next     = '0;
                header_count_next    = '0;
                in_payload_next      = 1'b0;
                payload_left_next    = '0;
                current_length_next  = '0;
                current_swapped_next = 1'b0;
                halted_next          = 1'b0;
            end
            else if (halted_reg)
            begin
                // Discard data until restart
            end
            else if (in_payload_reg)
            begin
                payload_left_next  = payload_left_reg - 16'd1;
                burst.count        = BURST_ONE;
                burst.bytes        = {byte_reg, 24'd0};
                burst.frame_end    = (payload_left_next == 16'd0);
                burst.frame_length = current_length_reg;
                burst.swapped      = current_swapped_reg;
                if (payload_left_next == 16'd0)
                begin
                    in_payload_next = 1'b0;
                end
            end
            else if (header_count_reg < HDR_LAST)
            begin
                header_hold_next  = {header_hold_reg[15:0], byte_reg};
                header_count_next = header_count_reg + 2'd1;
            end
            else if (big_ok || little_ok)
            begin
                // Accept the frame, big-endian reading first
                current_length_next  = big_ok ? big_len[15:0] : little_len[15:0];
                current_swapped_next = !big_ok;
                payload_left_next    = current_length_next;
                in_payload_next      = (current_length_next != 16'd0);
                header_hold_next     = '0;
                header_count_next    = '0;
                burst.count          = BURST_FULL;
                burst.bytes          = {header_hold_reg, byte_reg};
                burst.header         = 1'b1;
                burst.frame_end      = (current_length_next == 16'd0);
                burst.frame_length   = current_length_next;
                burst.swapped        = !big_ok;
            end
            else
            begin
                // Both readings too long: report and halt
                header_hold_next  = '0;
                header_count_next = '0;
                halted_next       = 1'b1;
                burst.count       = BURST_ONE;
                burst.error       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_hold_reg     <= '0;
            header_count_reg    <= '0;
            in_payload_reg      <= 1'b0;
            payload_left_reg    <= '0;
            current_length_reg  <= '0;
            current_swapped_reg <= 1'b0;
            halted_reg          <= 1'b0;
        end
        else
        begin
            header_hold_reg     <= header_hold_next;
            header_count_reg    <= header_count_next;
            in_payload_reg      <= in_payload_next;
            payload_left_reg    <= payload_left_next;
            current_length_reg  <= current_length_next;
            current_swapped_reg <= current_swapped_next;
            halted_reg          <= halted_next;
        end
    end

    // The error state never coexists with a frame in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !in_payload_reg && header_count_reg == 2'd0)
    else $error("ldf_parse: halted with a frame in progress");

    // A payload in progress always has bytes left to come
    assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> payload_left_reg != 16'd0)
    else $error("ldf_parse: payload active with nothing left");

    // A restart request clears the error state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && mode_reg == MODE_RESTART |=> !halted_reg && !in_payload_reg)
    else $error("ldf_parse: restart did not clear state");

endmodule

`default_nettype wire

// ===== hdl/ldf_emit.sv =====
// Result register: holds one burst and sends its results one per cycle while out_stall is low.
// Depends on ldf_pkg; loaded by ldf_parse.
`default_nettype none

module ldf_emit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ldf_pkg::burst_t burst,
    input  wire logic            burst_load,
    output logic                 emit_ready,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_byte,
    output logic                 is_header,
    output logic                 frame_start,
    output logic                 frame_end,
    output logic [15:0]          frame_length,
    output logic                 length_swapped,
    output logic                 length_error,
    output logic                 last_of_run
);
    import ldf_pkg::*;

    logic [2:0]  count_reg;
    logic [31:0] bytes_reg;
    logic        header_reg;
    logic        error_reg;
    logic        frame_end_reg;
    logic [15:0] frame_length_reg;
    logic        swapped_reg;
    logic        sent;

    assign out_valid  = (count_reg != BURST_EMPTY);
    assign sent       = out_valid && !out_stall;
    assign emit_ready = (count_reg == BURST_EMPTY) || (count_reg == BURST_ONE && !out_stall);

    // Load a new burst or advance through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= BURST_EMPTY;
        end
        else if (burst_load)
        begin
            count_reg <= burst.count;
        end
        else if (sent)
        begin
            count_reg <= count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            bytes_reg        <= burst.bytes;
            header_reg       <= burst.header;
            error_reg        <= burst.error;
            frame_end_reg    <= burst.frame_end;
            frame_length_reg <= burst.frame_length;
            swapped_reg      <= burst.swapped;
        end
        else if (sent)
        begin
            bytes_reg <= {bytes_reg[23:0], 8'd0};
        end
    end

    // Decode per-result flags from the position in the burst
    assign out_byte       = bytes_reg[31:24];
    assign is_header      = header_reg;
    assign frame_start    = header_reg && (count_reg == BURST_FULL);
    assign last_of_run    = (count_reg == BURST_ONE);
    assign frame_end      = frame_end_reg && last_of_run;
    assign frame_length   = frame_length_reg;
    assign length_swapped = swapped_reg;
    assign length_error   = error_reg;

    // A burst never exceeds one header
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BURST_FULL)
    else $error("ldf_emit: burst count out of range");

    // An error result stands alone and carries no header
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> last_of_run && !is_header)
    else $error("ldf_emit: malformed error result");

    // After the first header byte goes out, the second follows
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_start && !out_stall |=> out_valid && is_header && !frame_start)
    else $error("ldf_emit: header burst broken");

endmodule

`default_nettype wire

// ===== hdl/length_prefixed_deframer_core.sv =====
// Top level of the length-prefixed deframer: configuration register, parser, result stage.
// Depends on ldf_pkg, ldf_parse and ldf_emit.
`default_nettype none

// Splits a byte stream into frames that each open with a 4-byte length header.
// The header is read big-endian; if that exceeds the limit in max_len_reg the
// little-endian reading is used, and if both exceed it one error result is
// given and data is dropped until a restart request. Payload bytes pass
// through one result per cycle while out_stall is low, so a data request is
// then taken every cycle. The request that completes a header yields four
// results, sent one per cycle from the result register while out_stall is
// low; the input stalls until the last is sent. A request passes the input,
// then the result register. cfg_ready is always high; write the limit only while idle.
module length_prefixed_deframer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_header,
    output logic             frame_start,
    output logic             frame_end,
    output logic [15:0]      frame_length,
    output logic             length_swapped,
    output logic             length_error,
    output logic             last_of_run
);
    import ldf_pkg::*;

    logic [15:0] max_len_reg;
    burst_t      burst;
    logic        burst_load;
    logic        emit_ready;

    assign cfg_ready = 1'b1;

    // Hold the payload length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    ldf_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .data_byte  (data_byte),
        .max_len    (max_len_reg),
        .emit_ready (emit_ready),
        .burst      (burst),
        .burst_load (burst_load)
    );

    ldf_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .burst          (burst),
        .burst_load     (burst_load),
        .emit_ready     (emit_ready),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_header      (is_header),
        .frame_start    (frame_start),
        .frame_end      (frame_end),
        .frame_length   (frame_length),
        .length_swapped (length_swapped),
        .length_error   (length_error),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire
